// File: rtl/core/m3inv_pkg.sv
`default_nettype none
package m3inv_pkg;

  localparam int ElemW = 32;
  localparam int CofW  = 64;
  localparam int DetW  = 98;
  localparam int DshW  = DetW - 32;
  localparam int NDiv  = 32;
  localparam int NPre  = 6;
  // pre-stages, divide setup, divide steps, output register
  localparam int NVld  = NPre + 1 + NDiv + 1;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [CofW-1:0]         cof_t;
  typedef logic [DetW-1:0]         wide_t;

  // cofactor i = a[p]*a[q] - a[r]*a[s], listed as {p, q, r, s}
  localparam int CofIdx [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 4, 2},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    elem_t a00; elem_t a01; elem_t a02;
    elem_t a10; elem_t a11; elem_t a12;
    elem_t a20; elem_t a21; elem_t a22;
  } in_t;

  typedef struct packed {
    elem_t inv00; elem_t inv01; elem_t inv02;
    elem_t inv10; elem_t inv11; elem_t inv12;
    elem_t inv20; elem_t inv21; elem_t inv22;
    elem_t determinant_out;
    logic  singular;
    logic  clamped;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/core/m3inv_if.sv
`default_nettype none
interface m3inv_in_if import m3inv_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m3inv_out_if import m3inv_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/matrix3_inverse_adjugate.sv
// 3x3 matrix inverse by the adjugate, signed Q16.16.
// in_ch: one item is a whole matrix (a00..a22), taken when valid and ready.
// out_ch: one item per matrix: inv00..inv22, determinant_out, singular, clamped.
// Cofactors and the determinant are exact; each inverse element is the
// cofactor * 2^32 / det truncated toward zero, then saturated to 32 bits.
// Pipeline: 40 register stages (6 of multiply/add, one of compare setup,
// 32 restoring division steps, one output register). Throughput: one
// matrix per cycle while out_ch is not stalled; nine divide pipelines,
// one quotient bit per stage, run side by side.
// A zero determinant gives zero outputs with singular set.
// Reset (rst_n low, synchronous) empties every stage; no item is in flight.
// When the receiver stalls with a result waiting, the whole pipeline holds,
// in_ch.ready drops, and nothing is lost or repeated.
`default_nettype none
module matrix3_inverse_adjugate import m3inv_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  m3inv_in_if.sink     in_ch,
  m3inv_out_if.source  out_ch
);

  logic en;
  logic v_r [NVld];

  elem_t               a_in [9];
  elem_t               e_s1_r [3];
  elem_t               e_s2_r [3];
  logic signed [63:0]  prod_s1_r [18];
  cof_t                cof_s2_r [9];
  cof_t                cof_s3_r [9];
  cof_t                cof_s4_r [9];
  cof_t                cof_s5_r [9];
  logic signed [64:0]  plo_s3_r [3];
  logic signed [63:0]  phi_s3_r [3];
  logic signed [DetW-1:0] term_s4_r [3];
  logic signed [DetW-1:0] det_s5_r;
  wide_t               dmag_s6_r;
  logic                dneg_s6_r;
  logic                sing_s6_r;
  cof_t                cmag_s6_r [9];
  logic                cneg_s6_r [9];

  wide_t               rem_r  [NDiv+1][9];
  logic [31:0]         q_r    [NDiv+1][9];
  logic                big_r  [NDiv+1][9];
  logic                qneg_r [NDiv+1][9];
  wide_t               den_r  [NDiv+1];
  logic [DshW-1:0]     dsh_r  [NDiv+1];
  logic                dneg_r [NDiv+1];
  logic                sing_r [NDiv+1];

  wide_t               rem_nxt [NDiv][9];
  logic                qb_nxt  [NDiv][9];
  out_t                out_nxt;
  out_t                out_r;

  function automatic logic [32:0] sat32(input logic [31:0] q, input logic big,
                                        input logic neg);
    logic [31:0] lim;
    logic [31:0] m;
    logic        c;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    m   = q;
    c   = 1'b0;
    if (big || (q > lim)) begin
      m = lim;
      c = 1'b1;
    end
    return {c, neg ? (~m + 32'd1) : m};
  endfunction

  assign en           = !v_r[NVld-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = v_r[NVld-1];
  assign out_ch.data  = out_r;

  always_comb begin
    a_in[0] = in_ch.data.a00; a_in[1] = in_ch.data.a01; a_in[2] = in_ch.data.a02;
    a_in[3] = in_ch.data.a10; a_in[4] = in_ch.data.a11; a_in[5] = in_ch.data.a12;
    a_in[6] = in_ch.data.a20; a_in[7] = in_ch.data.a21; a_in[8] = in_ch.data.a22;
  end

  // restoring division: one quotient bit per stage
  always_comb begin
    logic [DetW:0] r2;
    logic [DetW:0] df;
    for (int k = 0; k < NDiv; k++) begin
      for (int i = 0; i < 9; i++) begin
        r2 = {rem_r[k][i], 1'b0};
        df = r2 - {1'b0, den_r[k]};
        qb_nxt[k][i]  = !df[DetW];
        rem_nxt[k][i] = df[DetW] ? r2[DetW-1:0] : df[DetW-1:0];
      end
    end
  end

  always_comb begin
    logic [32:0] s [10];
    logic        any;
    for (int i = 0; i < 9; i++) begin
      s[i] = sat32(q_r[NDiv][i], big_r[NDiv][i], qneg_r[NDiv][i]);
    end
    s[9] = sat32(dsh_r[NDiv][31:0], |dsh_r[NDiv][DshW-1:32], dneg_r[NDiv]);
    any = 1'b0;
    for (int i = 0; i < 10; i++) begin
      any = any | s[i][32];
    end
    out_nxt.inv00 = s[0][31:0]; out_nxt.inv01 = s[1][31:0];
    out_nxt.inv02 = s[2][31:0]; out_nxt.inv10 = s[3][31:0];
    out_nxt.inv11 = s[4][31:0]; out_nxt.inv12 = s[5][31:0];
    out_nxt.inv20 = s[6][31:0]; out_nxt.inv21 = s[7][31:0];
    out_nxt.inv22 = s[8][31:0];
    out_nxt.determinant_out = s[9][31:0];
    out_nxt.singular = sing_r[NDiv];
    out_nxt.clamped  = any;
    if (sing_r[NDiv]) begin
      out_nxt = '0;
      out_nxt.singular = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NVld; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int k = 1; k < NVld; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: the eighteen 32x32 products
      for (int i = 0; i < 9; i++) begin
        prod_s1_r[2*i]   <= a_in[CofIdx[i][0]] * a_in[CofIdx[i][1]];
        prod_s1_r[2*i+1] <= a_in[CofIdx[i][2]] * a_in[CofIdx[i][3]];
      end
      for (int j = 0; j < 3; j++) begin
        e_s1_r[j] <= a_in[j];
        e_s2_r[j] <= e_s1_r[j];
      end
      // stage 2: cofactors, wrapping at 64 bits
      for (int i = 0; i < 9; i++) begin
        cof_s2_r[i] <= prod_s1_r[2*i] - prod_s1_r[2*i+1];
        cof_s3_r[i] <= cof_s2_r[i];
        cof_s4_r[i] <= cof_s3_r[i];
        cof_s5_r[i] <= cof_s4_r[i];
      end
      // stage 3: element times cofactor, split into 32-bit halves
      for (int j = 0; j < 3; j++) begin
        plo_s3_r[j] <= e_s2_r[j] * $signed({1'b0, cof_s2_r[3*j][31:0]});
        phi_s3_r[j] <= e_s2_r[j] * $signed(cof_s2_r[3*j][63:32]);
      end
      // stage 4: rebuild the three wide terms
      for (int j = 0; j < 3; j++) begin
        term_s4_r[j] <= $signed({{(DetW-96){phi_s3_r[j][63]}}, phi_s3_r[j], 32'h0})
                      + $signed({{(DetW-65){plo_s3_r[j][64]}}, plo_s3_r[j]});
      end
      // stage 5: determinant
      det_s5_r <= term_s4_r[0] + term_s4_r[1] + term_s4_r[2];
      // stage 6: magnitudes and signs
      dneg_s6_r <= det_s5_r[DetW-1];
      dmag_s6_r <= det_s5_r[DetW-1] ? (~det_s5_r + DetW'(1)) : det_s5_r;
      sing_s6_r <= (det_s5_r == '0);
      for (int i = 0; i < 9; i++) begin
        cneg_s6_r[i] <= cof_s5_r[i][CofW-1];
        cmag_s6_r[i] <= cof_s5_r[i][CofW-1] ? (~cof_s5_r[i] + CofW'(1)) : cof_s5_r[i];
      end
      // divide setup: a quotient of 2^32 or more is flagged up front
      den_r[0]  <= dmag_s6_r;
      dsh_r[0]  <= dmag_s6_r[DetW-1:32];
      dneg_r[0] <= dneg_s6_r;
      sing_r[0] <= sing_s6_r;
      for (int i = 0; i < 9; i++) begin
        big_r[0][i]  <= {{(DetW-CofW){1'b0}}, cmag_s6_r[i]} >= dmag_s6_r;
        rem_r[0][i]  <= {{(DetW-CofW){1'b0}}, cmag_s6_r[i]};
        q_r[0][i]    <= '0;
        qneg_r[0][i] <= cneg_s6_r[i] ^ dneg_s6_r;
      end
      for (int k = 0; k < NDiv; k++) begin
        den_r[k+1]  <= den_r[k];
        dsh_r[k+1]  <= dsh_r[k];
        dneg_r[k+1] <= dneg_r[k];
        sing_r[k+1] <= sing_r[k];
        for (int i = 0; i < 9; i++) begin
          rem_r[k+1][i]  <= rem_nxt[k][i];
          q_r[k+1][i]    <= {q_r[k][i][30:0], qb_nxt[k][i]};
          big_r[k+1][i]  <= big_r[k][i];
          qneg_r[k+1][i] <= qneg_r[k][i];
        end
      end
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.singular |->
      out_ch.data.inv00 == '0 && out_ch.data.determinant_out == '0 &&
      !out_ch.data.clamped)
    else $error("singular result not zeroed");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted item not in first stage");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
